### src/glt_pkg.sv
// shared types and constants for the glyph lookup and text measure block
// used by glt_front, glt_back and glyph_lookup_text_measure
package glt_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int CODE_W  = 21;
  localparam int GW_W    = 8;
  localparam int ENTRY_W = 8;
  localparam int MEAS_W  = 16;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_INDEX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_HEIGHT     = 2'd2;

  localparam logic [8:0] GLYPH_COUNT_RST    = 9'd224;
  localparam logic [7:0] FALLBACK_INDEX_RST = 8'd31;
  localparam logic [7:0] ROW_HEIGHT_RST     = 8'd1;

  localparam logic [CODE_W-1:0] CH_NEWLINE = 21'd10;
  localparam logic [CODE_W-1:0] CH_RETURN  = 21'd13;

  localparam logic [MEAS_W-1:0] MEAS_MAX = '1;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_BREAK,
    KIND_GLYPH
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_COMPARE,
    ST_CHECK,
    ST_FALLBACK,
    ST_UPDATE,
    ST_RESULT
  } back_state_e;

  typedef struct packed {
    kind_e               kind;
    logic                is_newline;
    logic [ENTRY_W-1:0]  entry_index;
    logic [CODE_W-1:0]   code_point;
    logic [GW_W-1:0]     glyph_width;
    logic                first_of_text;
    logic                last_of_text;
  } item_t;

  // front to back: head of the queue
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  typedef struct packed {
    logic [8:0] glyph_count;
    logic [7:0] fallback_index;
    logic [7:0] row_height;
  } cfg_t;

endpackage

### src/glt_front.sv
// front part: accepts input words, classifies them and queues them
// depends on glt_pkg
module glt_front
  import glt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               command_i,
  input  logic [ENTRY_W-1:0] entry_index_i,
  input  logic [CODE_W-1:0]  code_point_i,
  input  logic [GW_W-1:0]    glyph_width_i,
  input  logic               first_of_text_i,
  input  logic               last_of_text_i,
  output queue_head_t        head_o,
  input  logic               pop_i
);

  item_t             slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  item_t             in_item;
  logic              push, pop;

  always_comb begin
    in_item               = '0;
    in_item.entry_index   = entry_index_i;
    in_item.code_point    = code_point_i;
    in_item.glyph_width   = glyph_width_i;
    in_item.first_of_text = first_of_text_i;
    in_item.last_of_text  = last_of_text_i;
    in_item.is_newline    = (code_point_i == CH_NEWLINE);
    if (!command_i) begin
      in_item.kind = KIND_LOAD;
    end else if (code_point_i == CH_NEWLINE || code_point_i == CH_RETURN) begin
      in_item.kind = KIND_BREAK;
    end else begin
      in_item.kind = KIND_GLYPH;
    end
  end

  assign in_stall_o = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = pop_i && (count_q != '0);

  assign head_o.valid = (count_q != '0);
  assign head_o.item  = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= in_item;
    end
  end

endmodule

### src/glt_back.sv
// back part: glyph table memory, binary search sequencer, measure state
// and output register; depends on glt_pkg
module glt_back
  import glt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  queue_head_t       head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [MEAS_W-1:0] line_width_o,
  output logic [MEAS_W-1:0] max_width_o,
  output logic [MEAS_W-1:0] text_height_o,
  output logic              found_o,
  output logic [GW_W-1:0]   used_width_o
);

  logic [CODE_W-1:0] codes_mem  [TABLE_DEPTH];
  logic [GW_W-1:0]   widths_mem [TABLE_DEPTH];
  logic [CODE_W-1:0] rd_code_q;
  logic [GW_W-1:0]   rd_width_q;

  back_state_e state_q, state_d;
  item_t       item_q;
  logic [CNT_W-1:0] lo_q, hi_q, mid_q;
  logic             found_q;
  logic [GW_W-1:0]  used_q;
  logic [MEAS_W-1:0] line_x_q, widest_q, nl_q;

  logic              out_valid_q;
  logic [MEAS_W-1:0] out_line_q, out_max_q, out_height_q;
  logic              out_found_q;
  logic [GW_W-1:0]   out_used_q;

  // sequencer outputs
  logic             mem_we;
  logic [IDX_W-1:0] rd_addr;
  logic             load_out;

  logic [CNT_W:0]   mid_sum;
  logic [CNT_W-1:0] mid;
  logic [CNT_W-1:0] hi_init;
  logic             in_search;
  logic             hit;
  logic             fb_ok;
  logic             out_free;

  logic [MEAS_W-1:0] base_x, base_w, base_n;
  logic [MEAS_W:0]   x_sum;
  logic [MEAS_W-1:0] x_next, w_next, n_next;
  logic [MEAS_W:0]   rows;
  logic [MEAS_W+8:0] height_prod;
  logic [MEAS_W-1:0] height_sat;

  assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid       = mid_sum[CNT_W:1];
  assign hi_init   = (32'(cfg_i.glyph_count) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                             : CNT_W'(cfg_i.glyph_count);
  assign in_search = (lo_q < hi_q);
  assign hit       = (lo_q != '0) && (rd_code_q == item_q.code_point);
  assign fb_ok     = (32'(cfg_i.fallback_index) < TABLE_DEPTH);
  assign out_free  = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (head_i.valid) begin
          state_d = (head_i.item.kind == KIND_GLYPH) ? ST_PROBE : ST_UPDATE;
        end
      end
      ST_PROBE:    state_d = in_search ? ST_COMPARE : ST_CHECK;
      ST_COMPARE:  state_d = ST_PROBE;
      ST_CHECK:    state_d = (!hit && fb_ok) ? ST_FALLBACK : ST_UPDATE;
      ST_FALLBACK: state_d = ST_UPDATE;
      ST_UPDATE:   state_d = ST_RESULT;
      ST_RESULT:   state_d = out_free ? ST_IDLE : ST_RESULT;
      default:     state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    pop_o    = 1'b0;
    mem_we   = 1'b0;
    load_out = 1'b0;
    rd_addr  = IDX_W'(item_q.entry_index);
    unique case (state_q)
      ST_IDLE:  pop_o = head_i.valid;
      ST_PROBE: begin
        // after the loop, read the entry just below lo
        rd_addr = in_search ? IDX_W'(mid) : IDX_W'(lo_q - 1'b1);
      end
      ST_CHECK: rd_addr = IDX_W'(cfg_i.fallback_index);
      ST_UPDATE: mem_we = (item_q.kind == KIND_LOAD) &&
                          (32'(item_q.entry_index) < TABLE_DEPTH);
      ST_RESULT: load_out = out_free;
      default: ;
    endcase
  end

  // measure arithmetic
  always_comb begin
    base_x = item_q.first_of_text ? '0 : line_x_q;
    base_w = item_q.first_of_text ? '0 : widest_q;
    base_n = item_q.first_of_text ? '0 : nl_q;
    x_sum  = {1'b0, base_x} + (MEAS_W + 1)'(used_q);
    w_next = base_w;
    n_next = base_n;
    if (item_q.kind == KIND_BREAK) begin
      x_next = '0;
      if (item_q.is_newline && !item_q.last_of_text && base_n != MEAS_MAX) begin
        n_next = base_n + 1'b1;
      end
    end else begin
      x_next = x_sum[MEAS_W] ? MEAS_MAX : x_sum[MEAS_W-1:0];
      if (x_next > base_w) begin
        w_next = x_next;
      end
    end
  end

  assign rows        = {1'b0, nl_q} + 1'b1;
  assign height_prod = (MEAS_W + 9)'(cfg_i.row_height) * (MEAS_W + 9)'(rows);
  assign height_sat  = (|height_prod[MEAS_W+8:MEAS_W]) ? MEAS_MAX
                                                       : height_prod[MEAS_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      line_x_q    <= '0;
      widest_q    <= '0;
      nl_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_UPDATE && item_q.kind != KIND_LOAD) begin
        line_x_q <= x_next;
        widest_q <= w_next;
        nl_q     <= n_next;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // search and payload registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        item_q  <= head_i.item;
        lo_q    <= '0;
        hi_q    <= hi_init;
        found_q <= 1'b0;
        used_q  <= '0;
      end
      ST_PROBE: mid_q <= mid;
      ST_COMPARE: begin
        if (item_q.code_point < rd_code_q) begin
          hi_q <= mid_q;
        end else begin
          lo_q <= mid_q + 1'b1;
        end
      end
      ST_CHECK: begin
        if (hit) begin
          found_q <= 1'b1;
          used_q  <= rd_width_q;
        end
      end
      ST_FALLBACK: used_q <= rd_width_q;
      default: ;
    endcase
    if (load_out) begin
      out_line_q   <= line_x_q;
      out_max_q    <= widest_q;
      out_height_q <= height_sat;
      out_found_q  <= found_q;
      out_used_q   <= used_q;
    end
  end

  // glyph table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      codes_mem[IDX_W'(item_q.entry_index)]  <= item_q.code_point;
      widths_mem[IDX_W'(item_q.entry_index)] <= item_q.glyph_width;
    end
    rd_code_q  <= codes_mem[rd_addr];
    rd_width_q <= widths_mem[rd_addr];
  end

  assign out_valid_o   = out_valid_q;
  assign line_width_o  = out_line_q;
  assign max_width_o   = out_max_q;
  assign text_height_o = out_height_q;
  assign found_o       = out_found_q;
  assign used_width_o  = out_used_q;

endmodule

### src/glyph_lookup_text_measure.sv
// glyph table lookup and text measure, top level: config registers,
// front queue and back sequencer; depends on glt_pkg, glt_front, glt_back
// a load, newline or return word passes from queue head through the update
// and result states; a glyph word runs a probe and a compare per search step (up to 9
// probes for 256 entries), then check, the optional fallback read, update and result
// one word at a time in the back; the 2-entry queue takes words meanwhile
// reset clears the measure state and queue, config returns to 224/31/1;
// table contents stay undefined until loaded
module glyph_lookup_text_measure
  import glt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  command_i,
  input  logic [ENTRY_W-1:0]    entry_index_i,
  input  logic [CODE_W-1:0]     code_point_i,
  input  logic [GW_W-1:0]       glyph_width_i,
  input  logic                  first_of_text_i,
  input  logic                  last_of_text_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [MEAS_W-1:0]     line_width_o,
  output logic [MEAS_W-1:0]     max_width_o,
  output logic [MEAS_W-1:0]     text_height_o,
  output logic                  found_o,
  output logic [GW_W-1:0]       used_width_o
);

  cfg_t        cfg_q;
  queue_head_t head;
  logic        pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.glyph_count    <= GLYPH_COUNT_RST;
      cfg_q.fallback_index <= FALLBACK_INDEX_RST;
      cfg_q.row_height     <= ROW_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_GLYPH_COUNT:    cfg_q.glyph_count    <= cfg_data_i;
        CFG_FALLBACK_INDEX: cfg_q.fallback_index <= cfg_data_i[7:0];
        CFG_ROW_HEIGHT:     cfg_q.row_height     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  glt_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .entry_index_i   (entry_index_i),
    .code_point_i    (code_point_i),
    .glyph_width_i   (glyph_width_i),
    .first_of_text_i (first_of_text_i),
    .last_of_text_i  (last_of_text_i),
    .head_o          (head),
    .pop_i           (pop)
  );

  glt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .line_width_o  (line_width_o),
    .max_width_o   (max_width_o),
    .text_height_o (text_height_o),
    .found_o       (found_o),
    .used_width_o  (used_width_o)
  );

endmodule

### tb/sv/tb.sv
// testbench for glyph_lookup_text_measure: fills the glyph table, then runs directed, config
// edge, hold-off, saturation and random texts under several idling phases, checking each result
// word against a local model; depends on glt_pkg and the block's sources
module tb;
  import glt_pkg::*;

  localparam logic CMD_LOAD     = 1'b0;
  localparam logic CMD_MEASURE  = 1'b1;
  localparam int   CODE_MAX     = 1114111;
  localparam int   MEAS_SAT     = 65535;
  localparam int   HOLD_CYCLES  = 400;
  localparam int   DRAIN_CYCLES = 30;
  localparam int   CYCLE_LIMIT  = 1000000;
  localparam int   PHASE_ITEMS  = 250;

  typedef struct packed {
    logic              cmd;
    logic [ENTRY_W-1:0] entry;
    logic [CODE_W-1:0] code;
    logic [GW_W-1:0]   gw;
    logic              first_txt;
    logic              last_txt;
  } glyph_word_t;

  typedef struct packed {
    logic [MEAS_W-1:0] line_w;
    logic [MEAS_W-1:0] max_w;
    logic [MEAS_W-1:0] height;
    logic              found;
    logic [GW_W-1:0]   used;
  } measure_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic                  command_i = 1'b0;
  logic [ENTRY_W-1:0]    entry_index_i = '0;
  logic [CODE_W-1:0]     code_point_i = '0;
  logic [GW_W-1:0]       glyph_width_i = '0;
  logic                  first_of_text_i = 1'b0;
  logic                  last_of_text_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [MEAS_W-1:0]     line_width_o;
  logic [MEAS_W-1:0]     max_width_o;
  logic [MEAS_W-1:0]     text_height_o;
  logic                  found_o;
  logic [GW_W-1:0]       used_width_o;

  // local copy of the table, the measure state and the registers
  logic [CODE_W-1:0] glyph_codes [TABLE_DEPTH];
  logic [GW_W-1:0]   glyph_widths [TABLE_DEPTH];
  int                line_x;
  int                widest;
  int                newline_total;
  logic [8:0]        glyph_count_cfg = GLYPH_COUNT_RST;
  logic [7:0]        fallback_cfg = FALLBACK_INDEX_RST;
  logic [7:0]        row_height_cfg = ROW_HEIGHT_RST;

  measure_t expected_measures [$];
  int       mismatches = 0;
  int       cycles = 0;
  int       send_idle_pct = 0;
  int       stall_pct = 0;
  logic     hold_tgl = 1'b0;
  logic     hold_seen = 1'b0;
  int       hold_left = 0;

  glyph_lookup_text_measure dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .entry_index_i  (entry_index_i),
    .code_point_i   (code_point_i),
    .glyph_width_i  (glyph_width_i),
    .first_of_text_i(first_of_text_i),
    .last_of_text_i (last_of_text_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .line_width_o   (line_width_o),
    .max_width_o    (max_width_o),
    .text_height_o  (text_height_o),
    .found_o        (found_o),
    .used_width_o   (used_width_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int sat16(int v);
    return (v > MEAS_SAT) ? MEAS_SAT : v;
  endfunction

  function automatic measure_t predict_measure(glyph_word_t w);
    measure_t        m;
    int              lo;
    int              hi;
    int              mid;
    logic            hit;
    logic [GW_W-1:0] used;
    hit = 1'b0;
    used = '0;
    if (w.cmd == CMD_LOAD) begin
      glyph_codes[w.entry] = w.code;
      glyph_widths[w.entry] = w.gw;
    end else begin
      if (w.first_txt) begin
        line_x = 0;
        widest = 0;
        newline_total = 0;
      end
      if (w.code == CH_NEWLINE || w.code == CH_RETURN) begin
        line_x = 0;
        if (w.code == CH_NEWLINE && !w.last_txt) newline_total = sat16(newline_total + 1);
      end else begin
        lo = 0;
        hi = (glyph_count_cfg > TABLE_DEPTH) ? TABLE_DEPTH : int'(glyph_count_cfg);
        while (lo < hi) begin
          mid = (lo + hi) / 2;
          if (w.code < glyph_codes[mid]) hi = mid;
          else lo = mid + 1;
        end
        if (lo != 0 && glyph_codes[lo-1] == w.code) begin
          hit = 1'b1;
          used = glyph_widths[lo-1];
        end else begin
          used = glyph_widths[fallback_cfg];
        end
        line_x = sat16(line_x + int'(used));
        if (line_x > widest) widest = line_x;
      end
    end
    m.line_w = MEAS_W'(line_x);
    m.max_w = MEAS_W'(widest);
    m.height = MEAS_W'(sat16(int'(row_height_cfg) * (newline_total + 1)));
    m.found = hit;
    m.used = used;
    return m;
  endfunction

  function automatic glyph_word_t load_word(int entry, int code, int gw);
    glyph_word_t w;
    w.cmd = CMD_LOAD;
    w.entry = ENTRY_W'(entry);
    w.code = CODE_W'(code);
    w.gw = GW_W'(gw);
    // flags mean nothing on a load
    w.first_txt = 1'($urandom_range(1));
    w.last_txt = 1'($urandom_range(1));
    return w;
  endfunction

  function automatic glyph_word_t measure_word(logic [CODE_W-1:0] code, logic first_txt,
                                               logic last_txt);
    glyph_word_t w;
    w.cmd = CMD_MEASURE;
    w.entry = ENTRY_W'($urandom);
    w.code = code;
    w.gw = GW_W'($urandom);
    w.first_txt = first_txt;
    w.last_txt = last_txt;
    return w;
  endfunction

  function automatic logic [CODE_W-1:0] pick_code();
    int span;
    int r;
    span = (glyph_count_cfg == 0 || glyph_count_cfg > TABLE_DEPTH) ? TABLE_DEPTH
                                                                    : int'(glyph_count_cfg);
    r = $urandom_range(99);
    if (r < 60) return glyph_codes[$urandom_range(span - 1)];
    if (r < 70) return CH_NEWLINE;
    if (r < 75) return CH_RETURN;
    // near miss next to a stored code
    if (r < 85) return glyph_codes[$urandom_range(TABLE_DEPTH - 1)] ^ CODE_W'(1);
    return CODE_W'($urandom_range(CODE_MAX));
  endfunction

  task automatic send_word(glyph_word_t w);
    in_valid_i <= 1'b1;
    command_i <= w.cmd;
    entry_index_i <= w.entry;
    code_point_i <= w.code;
    glyph_width_i <= w.gw;
    first_of_text_i <= w.first_txt;
    last_of_text_i <= w.last_txt;
    do @(posedge clk_i); while (in_stall_o);
    expected_measures.push_back(predict_measure(w));
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_measures.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= CFG_DATA_W'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_GLYPH_COUNT:    glyph_count_cfg = 9'(value);
      CFG_FALLBACK_INDEX: fallback_cfg = 8'(value);
      CFG_ROW_HEIGHT:     row_height_cfg = 8'(value);
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    stall_pct <= recv_pct;
  endtask

  // receiver: random stall, or a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_seen != hold_tgl) begin
      hold_seen = hold_tgl;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    measure_t got;
    measure_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {line_width_o, max_width_o, text_height_o, found_o, used_width_o};
      if (expected_measures.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: line %0d max %0d height %0d found %0b used %0d",
                   got.line_w, got.max_w, got.height, got.found, got.used);
      end else begin
        want = expected_measures.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: line %0d/%0d max %0d/%0d height %0d/%0d found %0b/%0b ",
                      "used %0d/%0d (expected/actual)"},
                     want.line_w, got.line_w, want.max_w, got.max_w, want.height, got.height,
                     want.found, got.found, want.used, got.used);
        end
      end
    end
  end

  // ascending codes: printable range, then sparse codes up to the top code point
  task automatic fill_table_test();
    int i;
    int code;
    int gw;
    set_idling(30, 30);
    code = 0;
    for (i = 0; i < TABLE_DEPTH; i++) begin
      if (i < 224) code = i + 32;
      else if (i == TABLE_DEPTH - 1) code = CODE_MAX;
      else code = code + $urandom_range(1, 34000);
      if (i == 1) gw = 0;
      else if (i == 2 || i == TABLE_DEPTH - 1) gw = 255;
      else gw = $urandom_range(1, 24);
      send_word(load_word(i, code, gw));
    end
    drain_results();
  endtask

  // runs with the reset register values
  task automatic directed_measure_test();
    set_idling(0, 0);
    send_word(measure_word(21'd32, 1'b1, 1'b0));
    send_word(measure_word(21'd33, 1'b0, 1'b0));
    send_word(measure_word(21'd34, 1'b0, 1'b0));
    send_word(measure_word(21'd0, 1'b0, 1'b0));
    send_word(measure_word(CODE_W'(CODE_MAX), 1'b0, 1'b0));
    send_word(measure_word(CH_NEWLINE, 1'b0, 1'b0));
    send_word(measure_word(CH_RETURN, 1'b0, 1'b0));
    send_word(measure_word(21'd255, 1'b0, 1'b0));
    send_word(load_word(100, 132, 200));
    send_word(measure_word(21'd132, 1'b0, 1'b0));
    send_word(measure_word(CH_NEWLINE, 1'b0, 1'b1));
    send_word(measure_word(21'd65, 1'b1, 1'b1));
    drain_results();
  endtask

  task automatic config_edge_test();
    // count beyond the table searches all entries
    write_reg(CFG_GLYPH_COUNT, 511);
    write_reg(CFG_ROW_HEIGHT, 255);
    send_word(measure_word(CODE_W'(CODE_MAX), 1'b1, 1'b0));
    send_word(measure_word(CH_NEWLINE, 1'b0, 1'b1));
    drain_results();
    write_reg(CFG_GLYPH_COUNT, 0);
    write_reg(CFG_FALLBACK_INDEX, 255);
    send_word(measure_word(21'd65, 1'b1, 1'b1));
    drain_results();
    write_reg(CFG_GLYPH_COUNT, 1);
    write_reg(CFG_FALLBACK_INDEX, 0);
    send_word(measure_word(21'd32, 1'b1, 1'b0));
    send_word(measure_word(21'd33, 1'b0, 1'b1));
    drain_results();
    // out-of-order entry in the middle of the table
    write_reg(CFG_GLYPH_COUNT, 256);
    write_reg(CFG_ROW_HEIGHT, 0);
    send_word(load_word(128, 5, 7));
    send_word(measure_word(21'd5, 1'b1, 1'b0));
    send_word(measure_word(21'd161, 1'b0, 1'b0));
    send_word(measure_word(CH_NEWLINE, 1'b0, 1'b1));
    send_word(load_word(128, 160, 9));
    drain_results();
    write_reg(CFG_FALLBACK_INDEX, 31);
    write_reg(CFG_ROW_HEIGHT, 1);
  endtask

  task automatic pressure_test();
    int k;
    set_idling(0, 0);
    hold_tgl <= ~hold_tgl;
    for (k = 0; k < 40; k++) send_word(measure_word(pick_code(), k == 0, k == 39));
    drain_results();
  endtask

  task automatic saturation_test();
    int k;
    set_idling(0, 10);
    write_reg(CFG_ROW_HEIGHT, 255);
    // widest glyph on one line until the width clips
    for (k = 0; k < 270; k++) send_word(measure_word(21'd34, k == 0, 1'b0));
    for (k = 0; k < 258; k++) send_word(measure_word(CH_NEWLINE, 1'b0, 1'b0));
    send_word(measure_word(CH_NEWLINE, 1'b0, 1'b1));
    drain_results();
  endtask

  task automatic random_text_test(int phase);
    int          sent;
    int          len;
    int          k;
    int          r;
    int          entry;
    logic        noisy;
    glyph_word_t w;
    case (phase)
      0: begin
        set_idling(0, 0);
        write_reg(CFG_GLYPH_COUNT, 256);
        write_reg(CFG_FALLBACK_INDEX, $urandom_range(255));
        write_reg(CFG_ROW_HEIGHT, $urandom_range(1, 255));
      end
      1: begin
        set_idling(82, 0);
        write_reg(CFG_GLYPH_COUNT, $urandom_range(1, 256));
        write_reg(CFG_FALLBACK_INDEX, $urandom_range(255));
        write_reg(CFG_ROW_HEIGHT, 1);
      end
      2: begin
        set_idling(0, 82);
        write_reg(CFG_GLYPH_COUNT, $urandom_range(1, 32));
        write_reg(CFG_FALLBACK_INDEX, 0);
        write_reg(CFG_ROW_HEIGHT, 255);
      end
      default: begin
        set_idling(30, 30);
        write_reg(CFG_GLYPH_COUNT, $urandom_range(257, 511));
        write_reg(CFG_FALLBACK_INDEX, 255);
        write_reg(CFG_ROW_HEIGHT, $urandom_range(1, 255));
      end
    endcase
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      len = $urandom_range(1, 12);
      noisy = ($urandom_range(99) < 15);
      for (k = 0; k < len; k++) begin
        r = $urandom_range(99);
        entry = $urandom_range(TABLE_DEPTH - 1);
        if (r < 4) begin
          // new width, code kept so the table stays sorted
          w = load_word(entry, int'(glyph_codes[entry]), $urandom_range(255));
        end else if (noisy && r < 8) begin
          w = load_word(entry, $urandom_range(CODE_MAX), $urandom_range(255));
        end else begin
          w = measure_word(pick_code(), k == 0, k == len - 1);
          if (noisy) begin
            w.first_txt = 1'($urandom_range(1));
            w.last_txt = 1'($urandom_range(1));
          end
        end
        send_word(w);
        sent++;
      end
    end
    drain_results();
  endtask

  initial begin
    line_x = 0;
    widest = 0;
    newline_total = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    fill_table_test();
    directed_measure_test();
    config_edge_test();
    pressure_test();
    saturation_test();
    for (int p = 0; p < 4; p++) random_text_test(p);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_measures.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
